FILE: rtl/core/ejt_pkg.sv
`default_nettype none
package ejt_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int MUL_LAT      = 4;
    localparam int PIPE_LAT     = CORDIC_LAT + 2 * MUL_LAT + 3;

    function automatic logic [31:0] cordic_gain(input int n);
        logic [63:0] p;
        logic [63:0] kq;
        logic [63:0] cand;
        logic [63:0] sq;
        p  = 64'd1 << 61;
        kq = '0;
        for (int i = 1; i < n; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        for (int b = 30; b >= 0; b--) begin
            cand = kq | (64'd1 << b);
            sq   = cand * cand;
            if ((sq >> 32) * (p >> 30) <= (64'd1 << 60)) begin
                kq = cand;
            end
        end
        return kq[31:0];
    endfunction

    // Reciprocal of the CORDIC gain for the configured number of iterations, Q31.
    localparam logic [31:0] GAIN_Q31 = cordic_gain(CORDIC_STEPS);

    localparam logic [2:0] ROW_ROT0  = 3'd0;
    localparam logic [2:0] ROW_ROT1  = 3'd1;
    localparam logic [2:0] ROW_ROT2  = 3'd2;
    localparam logic [2:0] ROW_SUBSP = 3'd3;
    localparam logic [2:0] ROW_VEL   = 3'd4;
    localparam logic [2:0] ROW_BIAS  = 3'd5;
    localparam int         NUM_ROWS  = 6;

    typedef logic signed [63:0] q64_t;

    localparam q64_t Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q64_t Q64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        q64_t s0, c0, s1, c1, s2, c2, qx, qy, qz;
    } trig_t;

    typedef struct packed {
        q64_t qx, qy, qz;
    } rate3_t;

    typedef struct packed {
        trig_t t;
        q64_t c2c1, s2c1, c2s1, s2s1, c1s0, c1c0, s2c0, s2s0;
        q64_t c2c0, c2s0, s2qy, c2qy, s1qx, wzx, wyx, wzy;
    } prod1_t;

    typedef struct packed {
        q64_t first, second, third;
    } row_t;

    // Arctangent of 2^-i as a binary angle, full turn = 2^32.
    function automatic logic [31:0] atan_rom(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h2000_0000;
            1:  v = 32'h12E4_051E;
            2:  v = 32'h09FB_385B;
            3:  v = 32'h0511_11D4;
            4:  v = 32'h028B_0D43;
            5:  v = 32'h0145_D7E1;
            6:  v = 32'h00A2_F61E;
            7:  v = 32'h0051_7C55;
            8:  v = 32'h0028_BE53;
            9:  v = 32'h0014_5F2F;
            10: v = 32'h000A_2F98;
            11: v = 32'h0005_17CC;
            12: v = 32'h0002_8BE6;
            13: v = 32'h0001_45F3;
            14: v = 32'h0000_A2FA;
            15: v = 32'h0000_517D;
            16: v = 32'h0000_28BE;
            17: v = 32'h0000_145F;
            18: v = 32'h0000_0A30;
            19: v = 32'h0000_0518;
            20: v = 32'h0000_028C;
            21: v = 32'h0000_0146;
            22: v = 32'h0000_00A3;
            23: v = 32'h0000_0051;
            24: v = 32'h0000_0029;
            25: v = 32'h0000_0014;
            26: v = 32'h0000_000A;
            27: v = 32'h0000_0005;
            28: v = 32'h0000_0003;
            29: v = 32'h0000_0001;
            30: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic q64_t sat_add(input q64_t a, input q64_t b);
        logic signed [64:0] s;
        q64_t r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? Q64_MIN : Q64_MAX;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic q64_t sat_neg(input q64_t a);
        q64_t r;
        if (a == Q64_MIN) begin
            r = Q64_MAX;
        end else begin
            r = -a;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ejt_cordic.sv
`default_nettype none
module ejt_cordic import ejt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] angle,
    output q64_t             sin_q,
    output q64_t             cos_q
);
    localparam int XW = 44;
    localparam int ZW = 34;
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    logic signed [XW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic [1:0]           q_reg [0:CORDIC_STEPS];
    logic [31:0]          sh;
    logic signed [XW-1:0] cr;
    logic signed [XW-1:0] sr;
    q64_t                 c64;
    q64_t                 s64;
    q64_t                 sin_reg;
    q64_t                 cos_reg;

    assign sh = angle + 32'h2000_0000;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= $signed(XW'({GAIN_Q31, 9'd0}));
            y_reg[0] <= '0;
            z_reg[0] <= $signed(ZW'(sh[29:0])) - $signed(ZW'(32'h2000_0000));
            q_reg[0] <= sh[31:30];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] rom;
        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign rom = $signed(ZW'(atan_rom(i)));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - rom;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + rom;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    assign cr  = (x_reg[CORDIC_STEPS] + XW'(128)) >>> 8;
    assign sr  = (y_reg[CORDIC_STEPS] + XW'(128)) >>> 8;
    assign c64 = 64'(cr);
    assign s64 = 64'(sr);

    always_ff @(posedge aclk) begin
        if (en) begin
            case (q_reg[CORDIC_STEPS])
                QUAD_I: begin
                    cos_reg <= c64;
                    sin_reg <= s64;
                end
                QUAD_II: begin
                    cos_reg <= -s64;
                    sin_reg <= c64;
                end
                QUAD_III: begin
                    cos_reg <= -c64;
                    sin_reg <= -s64;
                end
                default: begin
                    cos_reg <= s64;
                    sin_reg <= -c64;
                end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule
`default_nettype wire

FILE: rtl/core/ejt_mulq.sv
`default_nettype none
module ejt_mulq import ejt_pkg::*; (
    input  wire logic aclk,
    input  wire logic en,
    input  wire q64_t a,
    input  wire q64_t b,
    output q64_t      p
);
    logic [63:0] ua_reg;
    logic [63:0] ub_reg;
    logic        neg1_reg;
    logic [63:0] p0_reg;
    logic [63:0] p1_reg;
    logic [63:0] p2_reg;
    logic [63:0] p3_reg;
    logic        neg2_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic        neg3_reg;
    q64_t        p_reg;
    logic [33:0] mid;
    logic [64:0] nlo;
    logic [63:0] hi2;
    logic [63:0] mag;
    q64_t        p_next;

    assign mid = 34'(p0_reg[63:32]) + 34'(p1_reg[31:0]) + 34'(p2_reg[31:0]);
    assign nlo = {1'b0, lo_reg} + 65'h8000_0000;
    assign hi2 = hi_reg + 64'(nlo[64]);
    assign mag = {hi2[31:0], nlo[63:32]};

    always_comb begin
        if (hi2[63:32] != '0) begin
            p_next = neg3_reg ? Q64_MIN : Q64_MAX;
        end else if (neg3_reg) begin
            p_next = mag[63] ? Q64_MIN : -$signed(mag);
        end else begin
            p_next = mag[63] ? Q64_MAX : $signed(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg   <= a[63] ? 64'(-a) : 64'(a);
            ub_reg   <= b[63] ? 64'(-b) : 64'(b);
            neg1_reg <= a[63] ^ b[63];
            p0_reg   <= 64'(ua_reg[31:0]) * 64'(ub_reg[31:0]);
            p1_reg   <= 64'(ua_reg[31:0]) * 64'(ub_reg[63:32]);
            p2_reg   <= 64'(ua_reg[63:32]) * 64'(ub_reg[31:0]);
            p3_reg   <= 64'(ua_reg[63:32]) * 64'(ub_reg[63:32]);
            neg2_reg <= neg1_reg;
            lo_reg   <= {mid[31:0], p0_reg[31:0]};
            hi_reg   <= p3_reg + 64'(p1_reg[63:32]) + 64'(p2_reg[63:32]) + 64'(mid[33:32]);
            neg3_reg <= neg2_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

FILE: rtl/core/euler_xyz_joint_transform_core.sv
`default_nettype none
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   three angles, three rates
// m_        out        m_valid / m_ready   row kind, three values, last row
//
// Each transfer in yields six transfers out, one per cycle while m_ready is high.
// The first row is offered once the input has passed the CORDIC pipeline, two
// multiplier levels and three register stages behind them. New inputs enter
// while earlier ones are in flight; the six-row output port limits the rate.
// Reset clears the valid bits and the output sequencer; the pipeline holds in
// place when its last stage is full and the output buffer cannot take it.
module euler_xyz_joint_transform_core import ejt_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [31:0]       s_angle_x,
    input  wire logic [31:0]       s_angle_y,
    input  wire logic [31:0]       s_angle_z,
    input  wire logic signed [31:0] s_rate_x,
    input  wire logic signed [31:0] s_rate_y,
    input  wire logic signed [31:0] s_rate_z,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_row_kind,
    output logic signed [63:0]     m_value_first,
    output logic signed [63:0]     m_value_second,
    output logic signed [63:0]     m_value_third,
    output logic                   m_last_row
);
    logic              vld_reg [0:PIPE_LAT-1];
    logic              en;
    logic              ser_free;
    logic [31:0]       ax_reg, ay_reg, az_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    rate3_t            rd_reg [0:CORDIC_LAT-1];
    trig_t             t0;
    trig_t             td_reg [0:MUL_LAT-1];
    prod1_t            m1;
    prod1_t            md_reg [0:MUL_LAT-1];
    prod1_t            m2;
    q64_t              c2c1, s2c1, c2s1, s2s1, c1s0, c1c0, s2c0, s2s0;
    q64_t              c2c0, c2s0, s2qy, c2qy, s1qx, wzx, wyx, wzy;
    q64_t              c2s1s0, c2s1c0, s2s1s0, s2s1c0, c2c1qx, s2c1qx, s2c1wzx;
    q64_t              c2s1wyx, c2wzy, c2c1wzx, s2s1wyx, s2wzy, c1wyx;
    row_t              r3_reg [0:NUM_ROWS-1];
    q64_t              c2wzy_reg;
    q64_t              ns2wzy_reg;
    row_t              r4_reg [0:NUM_ROWS-1];
    row_t              buf_reg [0:NUM_ROWS-1];
    logic              busy_reg;
    logic [2:0]        cnt_reg;

    assign ser_free = !busy_reg || (m_ready && cnt_reg == ROW_BIAS);
    assign en       = !vld_reg[PIPE_LAT-1] || ser_free;
    assign s_ready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < PIPE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= s_angle_x;
            ay_reg <= s_angle_y;
            az_reg <= s_angle_z;
            rx_reg <= s_rate_x;
            ry_reg <= s_rate_y;
            rz_reg <= s_rate_z;
            rd_reg[0] <= {{{16{rx_reg[31]}}, rx_reg, 16'd0},
                          {{16{ry_reg[31]}}, ry_reg, 16'd0},
                          {{16{rz_reg[31]}}, rz_reg, 16'd0}};
            for (int k = 1; k < CORDIC_LAT; k++) begin
                rd_reg[k] <= rd_reg[k-1];
            end
            td_reg[0] <= t0;
            md_reg[0] <= m1;
            for (int k = 1; k < MUL_LAT; k++) begin
                td_reg[k] <= td_reg[k-1];
                md_reg[k] <= md_reg[k-1];
            end
        end
    end

    ejt_cordic u_cordic_x (.aclk(aclk), .en(en), .angle(ax_reg), .sin_q(t0.s0), .cos_q(t0.c0));
    ejt_cordic u_cordic_y (.aclk(aclk), .en(en), .angle(ay_reg), .sin_q(t0.s1), .cos_q(t0.c1));
    ejt_cordic u_cordic_z (.aclk(aclk), .en(en), .angle(az_reg), .sin_q(t0.s2), .cos_q(t0.c2));

    assign t0.qx = rd_reg[CORDIC_LAT-1].qx;
    assign t0.qy = rd_reg[CORDIC_LAT-1].qy;
    assign t0.qz = rd_reg[CORDIC_LAT-1].qz;

    ejt_mulq u_c2c1 (.aclk(aclk), .en(en), .a(t0.c2), .b(t0.c1), .p(c2c1));
    ejt_mulq u_s2c1 (.aclk(aclk), .en(en), .a(t0.s2), .b(t0.c1), .p(s2c1));
    ejt_mulq u_c2s1 (.aclk(aclk), .en(en), .a(t0.c2), .b(t0.s1), .p(c2s1));
    ejt_mulq u_s2s1 (.aclk(aclk), .en(en), .a(t0.s2), .b(t0.s1), .p(s2s1));
    ejt_mulq u_c1s0 (.aclk(aclk), .en(en), .a(t0.c1), .b(t0.s0), .p(c1s0));
    ejt_mulq u_c1c0 (.aclk(aclk), .en(en), .a(t0.c1), .b(t0.c0), .p(c1c0));
    ejt_mulq u_s2c0 (.aclk(aclk), .en(en), .a(t0.s2), .b(t0.c0), .p(s2c0));
    ejt_mulq u_s2s0 (.aclk(aclk), .en(en), .a(t0.s2), .b(t0.s0), .p(s2s0));
    ejt_mulq u_c2c0 (.aclk(aclk), .en(en), .a(t0.c2), .b(t0.c0), .p(c2c0));
    ejt_mulq u_c2s0 (.aclk(aclk), .en(en), .a(t0.c2), .b(t0.s0), .p(c2s0));
    ejt_mulq u_s2qy (.aclk(aclk), .en(en), .a(t0.s2), .b(t0.qy), .p(s2qy));
    ejt_mulq u_c2qy (.aclk(aclk), .en(en), .a(t0.c2), .b(t0.qy), .p(c2qy));
    ejt_mulq u_s1qx (.aclk(aclk), .en(en), .a(t0.s1), .b(t0.qx), .p(s1qx));
    ejt_mulq u_wzx  (.aclk(aclk), .en(en), .a(t0.qz), .b(t0.qx), .p(wzx));
    ejt_mulq u_wyx  (.aclk(aclk), .en(en), .a(t0.qy), .b(t0.qx), .p(wyx));
    ejt_mulq u_wzy  (.aclk(aclk), .en(en), .a(t0.qz), .b(t0.qy), .p(wzy));

    assign m1 = {td_reg[MUL_LAT-1], c2c1, s2c1, c2s1, s2s1, c1s0, c1c0, s2c0, s2s0,
                 c2c0, c2s0, s2qy, c2qy, s1qx, wzx, wyx, wzy};

    ejt_mulq u_c2s1s0  (.aclk(aclk), .en(en), .a(m1.c2s1), .b(m1.t.s0), .p(c2s1s0));
    ejt_mulq u_c2s1c0  (.aclk(aclk), .en(en), .a(m1.c2s1), .b(m1.t.c0), .p(c2s1c0));
    ejt_mulq u_s2s1s0  (.aclk(aclk), .en(en), .a(m1.s2s1), .b(m1.t.s0), .p(s2s1s0));
    ejt_mulq u_s2s1c0  (.aclk(aclk), .en(en), .a(m1.s2s1), .b(m1.t.c0), .p(s2s1c0));
    ejt_mulq u_c2c1qx  (.aclk(aclk), .en(en), .a(m1.c2c1), .b(m1.t.qx), .p(c2c1qx));
    ejt_mulq u_s2c1qx  (.aclk(aclk), .en(en), .a(m1.s2c1), .b(m1.t.qx), .p(s2c1qx));
    ejt_mulq u_s2c1wzx (.aclk(aclk), .en(en), .a(m1.s2c1), .b(m1.wzx), .p(s2c1wzx));
    ejt_mulq u_c2s1wyx (.aclk(aclk), .en(en), .a(m1.c2s1), .b(m1.wyx), .p(c2s1wyx));
    ejt_mulq u_c2wzy   (.aclk(aclk), .en(en), .a(m1.t.c2), .b(m1.wzy), .p(c2wzy));
    ejt_mulq u_c2c1wzx (.aclk(aclk), .en(en), .a(m1.c2c1), .b(m1.wzx), .p(c2c1wzx));
    ejt_mulq u_s2s1wyx (.aclk(aclk), .en(en), .a(m1.s2s1), .b(m1.wyx), .p(s2s1wyx));
    ejt_mulq u_s2wzy   (.aclk(aclk), .en(en), .a(m1.t.s2), .b(m1.wzy), .p(s2wzy));
    ejt_mulq u_c1wyx   (.aclk(aclk), .en(en), .a(m1.t.c1), .b(m1.wyx), .p(c1wyx));

    assign m2 = md_reg[MUL_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            r3_reg[0] <= {m2.c2c1, sat_add(m2.s2c0, c2s1s0),
                          sat_add(m2.s2s0, sat_neg(c2s1c0))};
            r3_reg[1] <= {sat_neg(m2.s2c1), sat_add(m2.c2c0, sat_neg(s2s1s0)),
                          sat_add(m2.c2s0, s2s1c0)};
            r3_reg[2] <= {m2.t.s1, sat_neg(m2.c1s0), m2.c1c0};
            r3_reg[3] <= {m2.t.s2, m2.t.c2, 64'sd0};
            r3_reg[4] <= {sat_add(c2c1qx, m2.s2qy), sat_add(sat_neg(s2c1qx), m2.c2qy),
                          sat_add(m2.s1qx, m2.t.qz)};
            r3_reg[5] <= {sat_add(sat_neg(s2c1wzx), sat_neg(c2s1wyx)),
                          sat_add(sat_neg(c2c1wzx), s2s1wyx), c1wyx};
            c2wzy_reg  <= c2wzy;
            ns2wzy_reg <= sat_neg(s2wzy);
            for (int k = 0; k < NUM_ROWS - 1; k++) begin
                r4_reg[k] <= r3_reg[k];
            end
            r4_reg[5] <= {sat_add(r3_reg[5].first, c2wzy_reg),
                          sat_add(r3_reg[5].second, ns2wzy_reg), r3_reg[5].third};
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[PIPE_LAT-1]) begin
            for (int k = 0; k < NUM_ROWS; k++) begin
                buf_reg[k] <= r4_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= ROW_ROT0;
        end else if (en && vld_reg[PIPE_LAT-1]) begin
            busy_reg <= 1'b1;
            cnt_reg  <= ROW_ROT0;
        end else if (busy_reg && m_ready) begin
            if (cnt_reg == ROW_BIAS) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    assign m_valid        = busy_reg;
    assign m_row_kind     = cnt_reg;
    assign m_value_first  = buf_reg[cnt_reg].first;
    assign m_value_second = buf_reg[cnt_reg].second;
    assign m_value_third  = buf_reg[cnt_reg].third;
    assign m_last_row     = (cnt_reg == ROW_BIAS);

endmodule
`default_nettype wire
